[design/prq_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// prq_pkg
// Shared constants and types for the priority ready queue scheduler.
// ---------------------------------------------------------------------------
package prq_pkg;

   localparam int PRIORITY_LEVELS = 16;
   localparam int THREAD_SLOTS    = 64;

   localparam int TID_W  = 6;  // thread id field width
   localparam int PRIO_W = 4;  // priority field width

   localparam int LVL_AW = $clog2(PRIORITY_LEVELS);
   localparam int TID_AW = $clog2(THREAD_SLOTS);

   localparam logic CMD_ENQUEUE  = 1'b0;
   localparam logic CMD_SCHEDULE = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_APP_RD,
      ST_APP_WR,
      ST_TAKE_RD,
      ST_TAKE_LNK,
      ST_TAKE_WR,
      ST_DONE
   } state_type;

endpackage

[design/priority_ready_queue_scheduler.sv]
`timescale 1ns / 1ps
// Sequence: an enqueue goes through append read, append write and done; a failed
// enqueue or an empty-queue schedule goes straight to done; a schedule may append the
// running thread first, then goes through take read, take link, take write and done.
// Throughput: one item at a time, paced by head/tail and link RAM read-modify-writes;
// the next transfer is taken the cycle after the result register loads. An item stays
// in done while an earlier result waits to be taken. Reset: synchronous; clears the
// FSM, queued marks, non-empty flags and running thread, not the link or head/tail RAMs.
// ---------------------------------------------------------------------------
// priority_ready_queue_scheduler
// Multilevel round-robin ready queues kept as linked lists in RAM.
// ---------------------------------------------------------------------------
module priority_ready_queue_scheduler (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_command,
   input  logic [prq_pkg::TID_W-1:0]  req_thread_id,
   input  logic [prq_pkg::PRIO_W-1:0] req_thread_priority,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [prq_pkg::TID_W-1:0]  rsp_running_thread,
   output logic                      rsp_running_valid,
   output logic                      rsp_switched,
   output logic                      rsp_enqueue_error,
   output logic                      rsp_ready_empty
);

   localparam int TA = prq_pkg::TID_AW;
   localparam int LA = prq_pkg::LVL_AW;

   prq_pkg::state_type state_ff, state_in;

   logic [prq_pkg::THREAD_SLOTS-1:0]    mark_ff, mark_in;
   logic [prq_pkg::PRIORITY_LEVELS-1:0] ne_ff, ne_in;
   logic [prq_pkg::TID_W-1:0]           cur_thread_ff, cur_thread_in;
   logic [LA-1:0]                       cur_prio_ff, cur_prio_in;
   logic                                cur_valid_ff, cur_valid_in;
   logic                                rsp_valid_ff, rsp_valid_in;

   logic          cmd_ff, cmd_in;
   logic [TA-1:0] atid_ff, atid_in;
   logic [LA-1:0] alvl_ff, alvl_in;
   logic [LA-1:0] take_lvl_ff, take_lvl_in;
   logic [TA-1:0] tail_hold_ff, tail_hold_in;
   logic          single_ff, single_in;
   logic          sw_ff, sw_in;
   logic          err_ff, err_in;

   logic [prq_pkg::TID_W-1:0] rsp_thread_ff, rsp_thread_in;
   logic rsp_run_ff, rsp_run_in, rsp_sw_ff, rsp_sw_in;
   logic rsp_err_ff, rsp_err_in, rsp_empty_ff, rsp_empty_in;

   // queue RAM word: {head, tail}
   logic            q_wr_en;
   logic [LA-1:0]   q_wr_addr, q_rd_addr;
   logic [2*TA-1:0] q_wr_data, q_rd_data;
   logic [TA-1:0]   q_head, q_tail;
   logic            l_wr_en;
   logic [TA-1:0]   l_wr_addr, l_wr_data, l_rd_addr, l_rd_data;

   logic [LA-1:0]   hi_lvl;
   logic [LA-1:0]   lvl_sat;
   logic            tid_bad;

   assign q_head = q_rd_data[2*TA-1:TA];
   assign q_tail = q_rd_data[TA-1:0];

   prq_ram #(.WIDTH(2*TA), .DEPTH(prq_pkg::PRIORITY_LEVELS)) u_queue_ram (
      .clock   (clock),
      .wr_en   (q_wr_en),
      .wr_addr (q_wr_addr),
      .wr_data (q_wr_data),
      .rd_addr (q_rd_addr),
      .rd_data (q_rd_data)
   );

   prq_ram #(.WIDTH(TA), .DEPTH(prq_pkg::THREAD_SLOTS)) u_link_ram (
      .clock   (clock),
      .wr_en   (l_wr_en),
      .wr_addr (l_wr_addr),
      .wr_data (l_wr_data),
      .rd_addr (l_rd_addr),
      .rd_data (l_rd_data)
   );

   // highest non-empty level (lowest index)
   always_comb begin
      hi_lvl = '0;
      for (int i = prq_pkg::PRIORITY_LEVELS - 1; i >= 0; i--) begin
         if (ne_ff[i]) hi_lvl = LA'(i);
      end
   end

   assign lvl_sat = (int'(req_thread_priority) >= prq_pkg::PRIORITY_LEVELS) ?
                    LA'(prq_pkg::PRIORITY_LEVELS - 1) : LA'(req_thread_priority);
   assign tid_bad = (int'(req_thread_id) >= prq_pkg::THREAD_SLOTS) ||
                    mark_ff[TA'(req_thread_id)];

   always_comb begin
      state_in      = state_ff;
      mark_in       = mark_ff;
      ne_in         = ne_ff;
      cur_thread_in = cur_thread_ff;
      cur_prio_in   = cur_prio_ff;
      cur_valid_in  = cur_valid_ff;
      rsp_valid_in  = rsp_valid_ff;
      cmd_in        = cmd_ff;
      atid_in       = atid_ff;
      alvl_in       = alvl_ff;
      take_lvl_in   = take_lvl_ff;
      tail_hold_in  = tail_hold_ff;
      single_in     = single_ff;
      sw_in         = sw_ff;
      err_in        = err_ff;
      rsp_thread_in = rsp_thread_ff;
      rsp_run_in    = rsp_run_ff;
      rsp_sw_in     = rsp_sw_ff;
      rsp_err_in    = rsp_err_ff;
      rsp_empty_in  = rsp_empty_ff;
      q_wr_en       = 1'b0;
      q_wr_addr     = alvl_ff;
      q_wr_data     = '0;
      q_rd_addr     = alvl_ff;
      l_wr_en       = 1'b0;
      l_wr_addr     = q_tail;
      l_wr_data     = atid_ff;
      l_rd_addr     = q_head;

      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;

      case (state_ff)
         prq_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd_in = req_command;
               err_in = 1'b0;
               sw_in  = 1'b0;
               if (req_command == prq_pkg::CMD_ENQUEUE) begin
                  alvl_in = lvl_sat;
                  atid_in = TA'(req_thread_id);
                  if (tid_bad) begin
                     err_in   = 1'b1;
                     state_in = prq_pkg::ST_DONE;
                  end else begin
                     state_in = prq_pkg::ST_APP_RD;
                  end
               end else if (ne_ff == '0) begin
                  state_in = prq_pkg::ST_DONE;
               end else if (cur_valid_ff && cur_prio_ff != '0 &&
                            !mark_ff[TA'(cur_thread_ff)]) begin
                  // running thread goes back to the tail of its level
                  atid_in  = TA'(cur_thread_ff);
                  alvl_in  = cur_prio_ff;
                  state_in = prq_pkg::ST_APP_RD;
               end else begin
                  state_in = prq_pkg::ST_TAKE_RD;
               end
            end
         end
         prq_pkg::ST_APP_RD: begin
            state_in = prq_pkg::ST_APP_WR;
         end
         prq_pkg::ST_APP_WR: begin
            if (ne_ff[alvl_ff]) begin
               l_wr_en   = 1'b1;
               l_wr_addr = q_tail;
               l_wr_data = atid_ff;
            end
            q_wr_en   = 1'b1;
            q_wr_addr = alvl_ff;
            q_wr_data = {(ne_ff[alvl_ff] ? q_head : atid_ff), atid_ff};
            mark_in[atid_ff] = 1'b1;
            ne_in[alvl_ff]   = 1'b1;
            state_in = (cmd_ff == prq_pkg::CMD_ENQUEUE) ? prq_pkg::ST_DONE :
                                                          prq_pkg::ST_TAKE_RD;
         end
         prq_pkg::ST_TAKE_RD: begin
            q_rd_addr   = hi_lvl;
            take_lvl_in = hi_lvl;
            state_in    = prq_pkg::ST_TAKE_LNK;
         end
         prq_pkg::ST_TAKE_LNK: begin
            q_rd_addr     = take_lvl_ff;
            l_rd_addr     = q_head;
            tail_hold_in  = q_tail;
            single_in     = (q_head == q_tail);
            if (q_head == q_tail) ne_in[take_lvl_ff] = 1'b0;
            mark_in[q_head] = 1'b0;
            sw_in         = !cur_valid_ff || (cur_thread_ff != prq_pkg::TID_W'(q_head));
            cur_thread_in = prq_pkg::TID_W'(q_head);
            cur_prio_in   = take_lvl_ff;
            cur_valid_in  = 1'b1;
            state_in      = prq_pkg::ST_TAKE_WR;
         end
         prq_pkg::ST_TAKE_WR: begin
            if (!single_ff) begin
               q_wr_en   = 1'b1;
               q_wr_addr = take_lvl_ff;
               q_wr_data = {l_rd_data, tail_hold_ff};
            end
            state_in = prq_pkg::ST_DONE;
         end
         prq_pkg::ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_thread_in = cur_valid_ff ? cur_thread_ff : '0;
               rsp_run_in    = cur_valid_ff;
               rsp_sw_in     = sw_ff;
               rsp_err_in    = err_ff;
               rsp_empty_in  = (ne_ff == '0);
               state_in      = prq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = prq_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= prq_pkg::ST_IDLE;
         mark_ff       <= '0;
         ne_ff         <= '0;
         cur_thread_ff <= '0;
         cur_prio_ff   <= '0;
         cur_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         mark_ff       <= mark_in;
         ne_ff         <= ne_in;
         cur_thread_ff <= cur_thread_in;
         cur_prio_ff   <= cur_prio_in;
         cur_valid_ff  <= cur_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      atid_ff       <= atid_in;
      alvl_ff       <= alvl_in;
      take_lvl_ff   <= take_lvl_in;
      tail_hold_ff  <= tail_hold_in;
      single_ff     <= single_in;
      sw_ff         <= sw_in;
      err_ff        <= err_in;
      rsp_thread_ff <= rsp_thread_in;
      rsp_run_ff    <= rsp_run_in;
      rsp_sw_ff     <= rsp_sw_in;
      rsp_err_ff    <= rsp_err_in;
      rsp_empty_ff  <= rsp_empty_in;
   end

   assign req_stall          = (state_ff != prq_pkg::ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_running_thread = rsp_thread_ff;
   assign rsp_running_valid  = rsp_run_ff;
   assign rsp_switched       = rsp_sw_ff;
   assign rsp_enqueue_error  = rsp_err_ff;
   assign rsp_ready_empty    = rsp_empty_ff;

   // no thread can be marked queued while every level is empty
   a_mark_vs_empty: assert property (@(posedge clock) disable iff (reset)
      (ne_ff == '0) |-> (mark_ff == '0))
      else $error("queued mark set with all levels empty");

   // a pop always leaves a running thread
   a_take_runs: assert property (@(posedge clock) disable iff (reset)
      (state_ff == prq_pkg::ST_TAKE_LNK) |=> cur_valid_ff)
      else $error("take did not start a thread");

   // an accepted transfer moves the sequencer out of idle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff != prq_pkg::ST_IDLE))
      else $error("accepted item left sequencer idle");

endmodule

[design/prq_ram.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// prq_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module prq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

[test/tb_priority_ready_queue_scheduler.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_priority_ready_queue_scheduler
// Drives enqueue and timeslice commands into the ready queue scheduler and
// checks every result against a cycle-free predictor of the ready lists,
// the running thread and the switch / error / empty flags. Directed cases
// come first, then random rounds shaped by the predicted queue state.
// ---------------------------------------------------------------------------
module tb_priority_ready_queue_scheduler;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int RANDOM_ITEMS  = 900;
   localparam int DRAIN_CYCLES  = 20;
   localparam int PHASE_ONE_END = 310;
   localparam int PHASE_TWO_END = 620;

   typedef struct {
      logic                       cmd;
      logic [prq_pkg::TID_W-1:0]  tid;
      logic [prq_pkg::PRIO_W-1:0] prio;
   } sched_req_type;

   typedef struct {
      logic [prq_pkg::TID_W-1:0] thread;
      logic                      running;
      logic                      switched;
      logic                      error;
      logic                      empty;
   } sched_outcome_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                       req_valid           = 1'b0;
   logic                       req_stall;
   logic                       req_command         = prq_pkg::CMD_ENQUEUE;
   logic [prq_pkg::TID_W-1:0]  req_thread_id       = '0;
   logic [prq_pkg::PRIO_W-1:0] req_thread_priority = '0;
   logic                       rsp_valid;
   logic                       rsp_stall           = 1'b0;
   logic [prq_pkg::TID_W-1:0]  rsp_running_thread;
   logic                       rsp_running_valid;
   logic                       rsp_switched;
   logic                       rsp_enqueue_error;
   logic                       rsp_ready_empty;

   sched_req_type     pending_reqs[$];
   sched_outcome_type expected_outcomes[$];
   int                sent_count  = 0;
   int                mismatches  = 0;
   int                cycle_count = 0;
   int                sender_idle_pct;
   int                receiver_idle_pct;

   // Predicted scheduler state
   logic [prq_pkg::TID_W-1:0]  link_tab[prq_pkg::THREAD_SLOTS];
   bit                         queued[prq_pkg::THREAD_SLOTS];
   logic [prq_pkg::TID_W-1:0]  head_of[prq_pkg::PRIORITY_LEVELS];
   logic [prq_pkg::TID_W-1:0]  tail_of[prq_pkg::PRIORITY_LEVELS];
   int                         depth_of[prq_pkg::PRIORITY_LEVELS];
   logic [prq_pkg::TID_W-1:0]  run_tid = '0;
   logic [prq_pkg::PRIO_W-1:0] run_lvl = '0;
   bit                         run_on  = 1'b0;

   priority_ready_queue_scheduler dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_command         (req_command),
      .req_thread_id       (req_thread_id),
      .req_thread_priority (req_thread_priority),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_running_thread  (rsp_running_thread),
      .rsp_running_valid   (rsp_running_valid),
      .rsp_switched        (rsp_switched),
      .rsp_enqueue_error   (rsp_enqueue_error),
      .rsp_ready_empty     (rsp_ready_empty)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   assign sender_idle_pct   = sent_count < PHASE_ONE_END ? 38 :
                              sent_count < PHASE_TWO_END ? 83 : 0;
   assign receiver_idle_pct = sent_count < PHASE_ONE_END ? 83 :
                              sent_count < PHASE_TWO_END ? 38 : 0;

   function automatic bit any_ready();
      int p;
      for (p = 0; p < prq_pkg::PRIORITY_LEVELS; p++)
         if (depth_of[p] != 0) return 1'b1;
      return 1'b0;
   endfunction

   function automatic void ready_append(logic [prq_pkg::TID_W-1:0] t,
                                        logic [prq_pkg::PRIO_W-1:0] l);
      if (depth_of[l] == 0) begin
         head_of[l] = t;
      end else begin
         link_tab[tail_of[l]] = t;
      end
      tail_of[l] = t;
      queued[t]  = 1'b1;
      depth_of[l]++;
   endfunction

   function automatic sched_outcome_type next_schedule_outcome(sched_req_type r);
      sched_outcome_type         o;
      logic [prq_pkg::TID_W-1:0] old_tid;
      bit                        old_on;
      bit                        found;
      int                        p;
      o = '{default: '0};
      if (r.cmd == prq_pkg::CMD_ENQUEUE) begin
         if (queued[r.tid]) o.error = 1'b1;
         else ready_append(r.tid, r.prio);
      end else if (any_ready()) begin
         old_tid = run_tid;
         old_on  = run_on;
         // the main thread at level 0 is never put back
         if (run_on && run_lvl != 0 && !queued[run_tid]) ready_append(run_tid, run_lvl);
         found = 1'b0;
         for (p = 0; p < prq_pkg::PRIORITY_LEVELS; p++) begin
            if (!found && depth_of[p] != 0) begin
               found   = 1'b1;
               run_tid = head_of[p];
               run_lvl = p[prq_pkg::PRIO_W-1:0];
               run_on  = 1'b1;
               depth_of[p]--;
               if (depth_of[p] != 0) head_of[p] = link_tab[run_tid];
               queued[run_tid] = 1'b0;
            end
         end
         o.switched = !old_on || old_tid != run_tid;
      end
      o.thread  = run_on ? run_tid : '0;
      o.running = run_on;
      o.empty   = !any_ready();
      return o;
   endfunction

   task automatic add_req(logic cmd, int tid, int prio);
      sched_req_type r;
      r.cmd  = cmd;
      r.tid  = tid[prq_pkg::TID_W-1:0];
      r.prio = prio[prq_pkg::PRIO_W-1:0];
      pending_reqs.push_back(r);
   endtask

   task automatic wait_drained();
      while (pending_reqs.size() != 0 || req_valid || expected_outcomes.size() != 0)
         @(negedge clock);
   endtask

   task automatic check_field(string name, int want, int got);
      if (want != got) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   // Builds one burst from the predicted state; returns the number of
   // items added.
   task automatic queue_round(output int added);
      bit picked[prq_pkg::THREAD_SLOTS];
      int total_queued;
      int fresh_pct;
      int n, k, r, tries, t;
      added        = 0;
      total_queued = 0;
      foreach (picked[i]) picked[i] = queued[i];
      foreach (depth_of[p]) total_queued += depth_of[p];
      fresh_pct = total_queued > 44 ? 15 : 45;
      n = $urandom_range(16, 4);
      // requeue the running thread at level 0, so once taken from there it is not put back
      if (run_on && (total_queued > 30 || $urandom_range(99) < 20)) begin
         add_req(prq_pkg::CMD_ENQUEUE, run_tid, 0);
         add_req(prq_pkg::CMD_SCHEDULE, $urandom_range(63), $urandom_range(15));
         added += 2;
      end
      for (k = 0; k < n; k++) begin
         r = $urandom_range(99);
         if (r < fresh_pct) begin
            t = $urandom_range(prq_pkg::THREAD_SLOTS - 1);
            for (tries = 0; tries < 8 && picked[t]; tries++)
               t = $urandom_range(prq_pkg::THREAD_SLOTS - 1);
            picked[t] = 1'b1;
            add_req(prq_pkg::CMD_ENQUEUE, t,
                    $urandom_range(99) < 25 ? 0 : $urandom_range(15));
            added++;
         end else if (r < fresh_pct + 12) begin
            add_req(prq_pkg::CMD_ENQUEUE, $urandom_range(63), $urandom_range(15));
            added++;
         end else begin
            add_req(prq_pkg::CMD_SCHEDULE, $urandom_range(63), $urandom_range(15));
            added++;
         end
      end
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   always @(posedge clock) begin : drive_req
      sched_req_type nxt;
      logic          load;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         load = pending_reqs.size() != 0 && $urandom_range(99) >= sender_idle_pct;
         if (load) begin
            nxt = pending_reqs.pop_front();
            req_command         <= nxt.cmd;
            req_thread_id       <= nxt.tid;
            req_thread_priority <= nxt.prio;
         end
         req_valid <= load;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= $urandom_range(99) < receiver_idle_pct;
      end
   end

   always @(posedge clock) begin : watch_channels
      sched_req_type     got_req;
      sched_outcome_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            got_req.cmd  = req_command;
            got_req.tid  = req_thread_id;
            got_req.prio = req_thread_priority;
            expected_outcomes.push_back(next_schedule_outcome(got_req));
            sent_count <= sent_count + 1;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_outcomes.size() == 0) begin
               mismatches++;
               $display("%0t: result transfer with nothing expected, expected none, actual %0d",
                        $time, rsp_running_thread);
            end else begin
               want = expected_outcomes.pop_front();
               check_field("running_thread", want.thread, rsp_running_thread);
               check_field("running_valid", want.running, rsp_running_valid);
               check_field("switched", want.switched, rsp_switched);
               check_field("enqueue_error", want.error, rsp_enqueue_error);
               check_field("ready_empty", want.empty, rsp_ready_empty);
            end
         end
      end
   end

   initial begin
      int done;
      int added;
      foreach (queued[i]) queued[i] = 1'b0;
      foreach (depth_of[p]) depth_of[p] = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // nothing to run, then main thread start and already-queued reject
      add_req(prq_pkg::CMD_SCHEDULE, 63, 15);
      add_req(prq_pkg::CMD_ENQUEUE, 0, 0);
      add_req(prq_pkg::CMD_ENQUEUE, 0, 3);
      add_req(prq_pkg::CMD_SCHEDULE, 0, 0);
      add_req(prq_pkg::CMD_ENQUEUE, 63, 15);
      add_req(prq_pkg::CMD_ENQUEUE, 42, 7);
      // main thread dropped, then self reselection at level 7
      add_req(prq_pkg::CMD_SCHEDULE, 21, 5);
      add_req(prq_pkg::CMD_SCHEDULE, 0, 0);
      // enqueue of the running thread: no second append on the next timeslice
      add_req(prq_pkg::CMD_ENQUEUE, 42, 2);
      add_req(prq_pkg::CMD_SCHEDULE, 0, 0);
      add_req(prq_pkg::CMD_SCHEDULE, 0, 0);
      add_req(prq_pkg::CMD_ENQUEUE, 63, 0);
      add_req(prq_pkg::CMD_ENQUEUE, 1, 0);
      add_req(prq_pkg::CMD_ENQUEUE, 2, 0);
      add_req(prq_pkg::CMD_SCHEDULE, 0, 0);
      add_req(prq_pkg::CMD_SCHEDULE, 0, 0);
      add_req(prq_pkg::CMD_SCHEDULE, 0, 0);
      add_req(prq_pkg::CMD_ENQUEUE, 42, 0);
      add_req(prq_pkg::CMD_SCHEDULE, 0, 0);
      add_req(prq_pkg::CMD_SCHEDULE, 0, 0);
      add_req(prq_pkg::CMD_SCHEDULE, 0, 0);
      add_req(prq_pkg::CMD_ENQUEUE, 21, 10);
      add_req(prq_pkg::CMD_ENQUEUE, 0, 9);
      add_req(prq_pkg::CMD_SCHEDULE, 0, 0);
      add_req(prq_pkg::CMD_SCHEDULE, 0, 0);
      wait_drained();

      done = 0;
      while (done < RANDOM_ITEMS) begin
         queue_round(added);
         done += added;
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_outcomes.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

[priority_ready_queue_scheduler.f]
design/prq_pkg.sv
design/prq_ram.sv
design/priority_ready_queue_scheduler.sv
test/tb_priority_ready_queue_scheduler.sv
